>>> design/ndef_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ndef_pkg
// Shared types and codes for the ndef record stream parser: the field kind
// codes, the decoded header flags, the queue entry and the result item.
// ---------------------------------------------------------------------------
package ndef_pkg;

    // field kind codes carried on the result channel
    localparam logic [2:0] FIELD_HEADER   = 3'd0;
    localparam logic [2:0] FIELD_TYPE_LEN = 3'd1;
    localparam logic [2:0] FIELD_PAY_LEN  = 3'd2;
    localparam logic [2:0] FIELD_ID_LEN   = 3'd3;
    localparam logic [2:0] FIELD_TYPE     = 3'd4;
    localparam logic [2:0] FIELD_ID       = 3'd5;
    localparam logic [2:0] FIELD_PAYLOAD  = 3'd6;
    localparam logic [2:0] FIELD_IGNORE   = 3'd7;

    // record_index saturates here even for large record tables
    localparam logic [7:0] INDEX_SAT = 8'd7;

    // header byte taken apart: MB, ME, CF, SR, IL, TNF
    typedef struct packed {
        logic       mb;
        logic       me;
        logic       cf;
        logic       sr;
        logic       il;
        logic [2:0] tnf;
    } hdr_t;

    // one classified byte waiting between front and back
    typedef struct packed {
        hdr_t       flags;
        logic [7:0] data;
        logic       last;
    } entry_t;

    typedef struct packed {
        logic [2:0] field_kind;
        logic [2:0] record_index;
        logic [2:0] record_tnf;
        logic       first_record;
        logic       last_record;
        logic       chunked;
        logic       record_done;
        logic       message_done;
        logic       dropped;
        logic       truncated;
    } result_t;

endpackage

>>> design/ndef_byte_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ndef_byte_if
// Request channel carrying one raw message byte and the buffer end mark.
// ---------------------------------------------------------------------------
interface ndef_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> design/ndef_label_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ndef_label_if
// Result channel carrying the field label and record flags of one byte.
// ---------------------------------------------------------------------------
interface ndef_label_if;
    logic       valid;
    logic       ready;
    logic [2:0] field_kind;
    logic [2:0] record_index;
    logic [2:0] record_tnf;
    logic       first_record;
    logic       last_record;
    logic       chunked;
    logic       record_done;
    logic       message_done;
    logic       dropped;
    logic       truncated;

    modport source (
        output valid, output field_kind, output record_index, output record_tnf,
        output first_record, output last_record, output chunked,
        output record_done, output message_done, output dropped, output truncated,
        input ready
    );
    modport sink (
        input valid, input field_kind, input record_index, input record_tnf,
        input first_record, input last_record, input chunked,
        input record_done, input message_done, input dropped, input truncated,
        output ready
    );
endinterface

>>> design/ndef_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ndef_front
// Accepts incoming bytes while the queue has room and decodes the header
// flag bits of each byte ahead of the parser.
// ---------------------------------------------------------------------------
module ndef_front
(
    ndef_byte_if.sink        msg,
    input  logic             full,
    output logic             push,
    output ndef_pkg::entry_t entry
);

    assign msg.ready = !full;
    assign push      = msg.valid && !full;

    always_comb
    begin
        entry.flags.mb  = msg.data_byte[7];
        entry.flags.me  = msg.data_byte[6];
        entry.flags.cf  = msg.data_byte[5];
        entry.flags.sr  = msg.data_byte[4];
        entry.flags.il  = msg.data_byte[3];
        entry.flags.tnf = msg.data_byte[2:0];
        entry.data      = msg.data_byte;
        entry.last      = msg.last_byte;
    end

endmodule

>>> design/ndef_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ndef_queue
// Two-entry queue between front and back; full does not depend on pop, so
// the request side never waits on the result side combinationally.
// ---------------------------------------------------------------------------
module ndef_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ndef_pkg::entry_t push_entry,
    output logic             full,
    output logic             head_valid,
    output ndef_pkg::entry_t head_entry,
    input  logic             pop
);

    ndef_pkg::entry_t slot_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

endmodule

>>> design/ndef_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ndef_back
// Record parser: walks header, length and body sections one byte per cycle
// unless a label stalls; counts records per message and holds the result in an output register.
// ---------------------------------------------------------------------------
module ndef_back
#(
    parameter int MAX_RECORDS = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  ndef_pkg::entry_t head_entry,
    output logic             pop,
    ndef_label_if.source     label
);

    localparam int SEEN_W = $clog2(MAX_RECORDS + 1);

    typedef enum logic [7:0] {
        PH_HEADER   = 8'b0000_0001,
        PH_TYPE_LEN = 8'b0000_0010,
        PH_PAY_LEN  = 8'b0000_0100,
        PH_ID_LEN   = 8'b0000_1000,
        PH_TYPE     = 8'b0001_0000,
        PH_ID       = 8'b0010_0000,
        PH_PAYLOAD  = 8'b0100_0000,
        PH_IGNORE   = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic        empty;
        phase_t      phase;
        logic [31:0] left;
    } sect_t;

    // first non-empty section from type, id or payload on
    function automatic sect_t enter_sect(input logic from_type, input logic from_id,
                                         input logic [7:0] tl, input logic [7:0] idl,
                                         input logic [31:0] pl);
        sect_t s;
        s.empty = 1'b0;
        s.phase = PH_PAYLOAD;
        s.left  = pl;
        if (from_type && tl != 8'd0)
        begin
            s.phase = PH_TYPE;
            s.left  = 32'(tl);
        end
        else if (from_id && idl != 8'd0)
        begin
            s.phase = PH_ID;
            s.left  = 32'(idl);
        end
        else if (pl == 32'd0)
        begin
            s.empty = 1'b1;
            s.phase = PH_HEADER;
        end
        return s;
    endfunction

    function automatic logic [2:0] phase_kind(input phase_t ph);
        logic [2:0] k;
        case (ph)
            PH_HEADER:   k = ndef_pkg::FIELD_HEADER;
            PH_TYPE_LEN: k = ndef_pkg::FIELD_TYPE_LEN;
            PH_PAY_LEN:  k = ndef_pkg::FIELD_PAY_LEN;
            PH_ID_LEN:   k = ndef_pkg::FIELD_ID_LEN;
            PH_TYPE:     k = ndef_pkg::FIELD_TYPE;
            PH_ID:       k = ndef_pkg::FIELD_ID;
            PH_PAYLOAD:  k = ndef_pkg::FIELD_PAYLOAD;
            default:     k = ndef_pkg::FIELD_IGNORE;
        endcase
        return k;
    endfunction

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [31:0]         bytes_left_reg;
    logic [31:0]         bytes_left_next;
    logic [1:0]          len_cnt_reg;
    logic [1:0]          len_cnt_next;
    logic [7:0]          type_len_reg;
    logic [7:0]          type_len_next;
    logic [7:0]          id_len_reg;
    logic [7:0]          id_len_next;
    logic [31:0]         pay_len_reg;
    logic [31:0]         pay_len_next;
    ndef_pkg::hdr_t      hdr_reg;
    ndef_pkg::hdr_t      hdr_next;
    logic [SEEN_W-1:0]   seen_reg;
    logic [SEEN_W-1:0]   seen_next;
    ndef_pkg::result_t   out_reg;
    ndef_pkg::result_t   out_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    logic                step;
    ndef_pkg::hdr_t      hdr;
    logic [7:0]          seen_ext;
    logic [31:0]         left_dec;
    logic                left_end;
    logic                len_end;
    logic                done;
    logic                msg_done;
    sect_t               sect;

    assign step = head_valid && (!out_valid_reg || label.ready);
    assign pop  = step;

    assign left_dec = (bytes_left_reg != 32'd0) ? bytes_left_reg - 32'd1 : 32'd0;
    assign left_end = (left_dec == 32'd0);
    assign seen_ext = 8'(seen_reg);

    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        len_cnt_next    = len_cnt_reg;
        type_len_next   = type_len_reg;
        id_len_next     = id_len_reg;
        pay_len_next    = pay_len_reg;
        hdr_next        = hdr_reg;
        seen_next       = seen_reg;
        done            = 1'b0;
        msg_done        = 1'b0;
        len_end         = 1'b0;
        sect            = '0;
        out_next        = '0;
        hdr             = (phase_reg == PH_HEADER) ? head_entry.flags : hdr_reg;

        if (phase_reg == PH_IGNORE)
        begin
            // rest of buffer after an ME record
            if (head_entry.last)
            begin
                phase_next = PH_HEADER;
            end
            out_next.field_kind = ndef_pkg::FIELD_IGNORE;
        end
        else
        begin
            hdr_next = hdr;
            case (phase_reg)
                PH_HEADER:
                begin
                    type_len_next   = 8'd0;
                    id_len_next     = 8'd0;
                    pay_len_next    = 32'd0;
                    len_cnt_next    = 2'd0;
                    bytes_left_next = 32'd0;
                    phase_next      = PH_TYPE_LEN;
                end
                PH_TYPE_LEN:
                begin
                    type_len_next = head_entry.data;
                    phase_next    = PH_PAY_LEN;
                end
                PH_PAY_LEN:
                begin
                    if (hdr.sr)
                    begin
                        pay_len_next = 32'(head_entry.data);
                        len_end      = 1'b1;
                    end
                    else
                    begin
                        // big-endian, most significant byte first
                        pay_len_next = {pay_len_reg[23:0], head_entry.data};
                        len_end      = (len_cnt_reg == 2'd3);
                        len_cnt_next = len_cnt_reg + 2'd1;
                    end
                    if (len_end)
                    begin
                        if (hdr.il)
                        begin
                            phase_next = PH_ID_LEN;
                        end
                        else
                        begin
                            sect = enter_sect(1'b1, 1'b1, type_len_reg, id_len_reg,
                                              pay_len_next);
                            done = sect.empty;
                        end
                    end
                end
                PH_ID_LEN:
                begin
                    id_len_next = head_entry.data;
                    sect = enter_sect(1'b1, 1'b1, type_len_reg, head_entry.data,
                                      pay_len_reg);
                    done = sect.empty;
                end
                PH_TYPE:
                begin
                    bytes_left_next = left_dec;
                    if (left_end)
                    begin
                        sect = enter_sect(1'b0, 1'b1, type_len_reg, id_len_reg,
                                          pay_len_reg);
                        done = sect.empty;
                    end
                end
                PH_ID:
                begin
                    bytes_left_next = left_dec;
                    if (left_end)
                    begin
                        sect = enter_sect(1'b0, 1'b0, type_len_reg, id_len_reg,
                                          pay_len_reg);
                        done = sect.empty;
                    end
                end
                PH_PAYLOAD:
                begin
                    bytes_left_next = left_dec;
                    done            = left_end;
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase

            // a non-empty section was entered
            if ((len_end && !hdr.il) || phase_reg == PH_ID_LEN
                || (left_end && (phase_reg == PH_TYPE || phase_reg == PH_ID)))
            begin
                if (!sect.empty)
                begin
                    phase_next      = sect.phase;
                    bytes_left_next = sect.left;
                end
            end

            if (done)
            begin
                out_next.record_done = 1'b1;
                if (seen_reg >= SEEN_W'(MAX_RECORDS))
                begin
                    out_next.dropped = 1'b1;
                end
                else
                begin
                    seen_next = seen_reg + SEEN_W'(1);
                end
                phase_next = PH_HEADER;
                if (hdr.me)
                begin
                    msg_done = 1'b1;
                    if (!head_entry.last)
                    begin
                        phase_next = PH_IGNORE;
                    end
                end
                else if (head_entry.last)
                begin
                    msg_done = 1'b1;
                end
            end
            else if (head_entry.last)
            begin
                out_next.truncated = 1'b1;
                msg_done           = 1'b1;
                phase_next         = PH_HEADER;
            end
            if (msg_done)
            begin
                seen_next = '0;
            end

            out_next.field_kind   = phase_kind(phase_reg);
            out_next.record_index = (seen_ext > ndef_pkg::INDEX_SAT) ? 3'd7 : seen_ext[2:0];
            out_next.record_tnf   = hdr.tnf;
            out_next.first_record = hdr.mb;
            out_next.last_record  = hdr.me;
            out_next.chunked      = hdr.cf;
            out_next.message_done = msg_done;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (label.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            bytes_left_reg <= 32'd0;
            len_cnt_reg    <= 2'd0;
            type_len_reg   <= 8'd0;
            id_len_reg     <= 8'd0;
            pay_len_reg    <= 32'd0;
            hdr_reg        <= '0;
            seen_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (step)
            begin
                phase_reg      <= phase_next;
                bytes_left_reg <= bytes_left_next;
                len_cnt_reg    <= len_cnt_next;
                type_len_reg   <= type_len_next;
                id_len_reg     <= id_len_next;
                pay_len_reg    <= pay_len_next;
                hdr_reg        <= hdr_next;
                seen_reg       <= seen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= out_next;
        end
    end

    assign label.valid        = out_valid_reg;
    assign label.field_kind   = out_reg.field_kind;
    assign label.record_index = out_reg.record_index;
    assign label.record_tnf   = out_reg.record_tnf;
    assign label.first_record = out_reg.first_record;
    assign label.last_record  = out_reg.last_record;
    assign label.chunked      = out_reg.chunked;
    assign label.record_done  = out_reg.record_done;
    assign label.message_done = out_reg.message_done;
    assign label.dropped      = out_reg.dropped;
    assign label.truncated    = out_reg.truncated;

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= SEEN_W'(MAX_RECORDS))
        else $error("record count beyond table size");

    a_msg_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (step && msg_done) |=> seen_reg == '0)
        else $error("record count not cleared at message end");

    a_drop_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.dropped) |-> out_reg.record_done)
        else $error("dropped without record completion");

    a_trunc_ends_msg: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.truncated)
            |-> (out_reg.message_done && !out_reg.record_done))
        else $error("truncation flags inconsistent");

    a_ignore_label: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_IGNORE) |=> out_reg.field_kind == ndef_pkg::FIELD_IGNORE)
        else $error("ignored byte labelled as record field");

endmodule

>>> design/ndef_record_stream_parser_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ndef_record_stream_parser_core
// Labels every byte of an NDEF message with its record field and reports
// record and message boundaries, dropped records and truncated buffers.
// ---------------------------------------------------------------------------
// a byte's label is registered in a queue slot and then in the output register before it is offered
// throughput: one byte per cycle unless a label stalls, set by the parser step
// a two-entry queue lets the byte side keep flowing while a label is stalled, until the queue is full
// reset clears the queue, the output valid flag and the parser to header phase
// ---------------------------------------------------------------------------
module ndef_record_stream_parser_core
#(
    parameter int MAX_RECORDS = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    ndef_byte_if.sink    msg,
    ndef_label_if.source label
);

    logic             push;
    logic             full;
    logic             head_valid;
    logic             pop;
    ndef_pkg::entry_t push_entry;
    ndef_pkg::entry_t head_entry;

    ndef_front u_front
    (
        .msg   (msg),
        .full  (full),
        .push  (push),
        .entry (push_entry)
    );

    ndef_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop)
    );

    ndef_back
    #(
        .MAX_RECORDS (MAX_RECORDS)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .label      (label)
    );

endmodule

>>> test/tb_ndef_record_stream_parser_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_ndef_record_stream_parser_core
// Drives NDEF byte buffers into the parser and checks the label of every
// byte against an in-bench model of the record decoder. A directed set of
// buffers (empty record, ME on the buffer end, bytes ignored after ME, long
// length with IL, truncation) is followed by random messages, mostly well
// formed, with dropped records, cut buffers and noise mixed in. Both
// channels stall at random in two idle settings and run with no idle in a third.
// ---------------------------------------------------------------------------
module tb_ndef_record_stream_parser_core;

    localparam int REC_SLOTS    = 4;
    localparam int TARGET_BYTES = 1250;
    localparam int TAIL_CYCLES  = 8;

    // tracks the parser state and holds the labels still to come out
    class field_labeler;
        ndef_pkg::result_t labels_due[$];
        logic [2:0]        phase;
        logic [31:0]       bytes_left;
        logic [1:0]        len_count;
        logic [7:0]        type_len;
        logic [7:0]        id_len;
        logic [31:0]       pay_len;
        ndef_pkg::hdr_t    hdr;
        logic [7:0]        recs_done;
        int                slots;
        int                errors;
        int                labelled;
        int                ignored;
        int                records;
        int                messages;
        int                drops;
        int                truncs;

        function new(int slot_count);
            slots      = slot_count;
            phase      = ndef_pkg::FIELD_HEADER;
            bytes_left = '0;
            len_count  = '0;
            type_len   = '0;
            id_len     = '0;
            pay_len    = '0;
            hdr        = '0;
            recs_done  = '0;
            errors     = 0;
            labelled   = 0;
            ignored    = 0;
            records    = 0;
            messages   = 0;
            drops      = 0;
            truncs     = 0;
        endfunction

        // move to the first non-empty section at or after the given one,
        // returns 1 when the record has nothing left
        function bit skip_to_section(logic [2:0] from);
            if (from <= ndef_pkg::FIELD_TYPE && type_len != 0)
            begin
                phase      = ndef_pkg::FIELD_TYPE;
                bytes_left = {24'd0, type_len};
                return 1'b0;
            end
            if (from <= ndef_pkg::FIELD_ID && id_len != 0)
            begin
                phase      = ndef_pkg::FIELD_ID;
                bytes_left = {24'd0, id_len};
                return 1'b0;
            end
            if (pay_len != 0)
            begin
                phase      = ndef_pkg::FIELD_PAYLOAD;
                bytes_left = pay_len;
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function bit consume_byte();
            if (bytes_left != 0)
                bytes_left = bytes_left - 1;
            return bytes_left == 0;
        endfunction

        function void take_byte(logic [7:0] value, logic is_last);
            ndef_pkg::result_t r;
            bit                done;
            bit                len_end;
            r    = '0;
            done = 1'b0;
            if (phase == ndef_pkg::FIELD_IGNORE)
            begin
                if (is_last)
                    phase = ndef_pkg::FIELD_HEADER;
                r.field_kind = ndef_pkg::FIELD_IGNORE;
                ignored++;
                labels_due.push_back(r);
                return;
            end
            labelled++;
            if (phase == ndef_pkg::FIELD_HEADER)
                hdr = value;
            r.field_kind   = phase;
            r.record_index = (recs_done > ndef_pkg::INDEX_SAT) ? 3'(ndef_pkg::INDEX_SAT)
                                                                : recs_done[2:0];
            r.record_tnf   = hdr.tnf;
            r.first_record = hdr.mb;
            r.last_record  = hdr.me;
            r.chunked      = hdr.cf;
            case (phase)
                ndef_pkg::FIELD_HEADER:
                begin
                    type_len   = '0;
                    id_len     = '0;
                    pay_len    = '0;
                    len_count  = '0;
                    bytes_left = '0;
                    phase      = ndef_pkg::FIELD_TYPE_LEN;
                end
                ndef_pkg::FIELD_TYPE_LEN:
                begin
                    type_len = value;
                    phase    = ndef_pkg::FIELD_PAY_LEN;
                end
                ndef_pkg::FIELD_PAY_LEN:
                begin
                    if (hdr.sr)
                    begin
                        pay_len = {24'd0, value};
                        len_end = 1'b1;
                    end
                    else
                    begin
                        // long form, most significant byte first
                        pay_len   = {pay_len[23:0], value};
                        len_end   = (len_count == 2'd3);
                        len_count = len_count + 2'd1;
                    end
                    if (len_end)
                    begin
                        if (hdr.il)
                            phase = ndef_pkg::FIELD_ID_LEN;
                        else
                            done = skip_to_section(ndef_pkg::FIELD_TYPE);
                    end
                end
                ndef_pkg::FIELD_ID_LEN:
                begin
                    id_len = value;
                    done   = skip_to_section(ndef_pkg::FIELD_TYPE);
                end
                ndef_pkg::FIELD_TYPE:
                begin
                    if (consume_byte())
                        done = skip_to_section(ndef_pkg::FIELD_ID);
                end
                ndef_pkg::FIELD_ID:
                begin
                    if (consume_byte())
                        done = skip_to_section(ndef_pkg::FIELD_PAYLOAD);
                end
                default:
                begin
                    done = consume_byte();
                end
            endcase
            if (done)
            begin
                r.record_done = 1'b1;
                records++;
                if (recs_done >= slots)
                begin
                    r.dropped = 1'b1;
                    drops++;
                end
                else
                    recs_done = recs_done + 8'd1;
                phase = ndef_pkg::FIELD_HEADER;
                if (hdr.me)
                begin
                    r.message_done = 1'b1;
                    // rest of the buffer is skipped up to its end mark
                    if (!is_last)
                        phase = ndef_pkg::FIELD_IGNORE;
                end
                else if (is_last)
                    r.message_done = 1'b1;
            end
            else if (is_last)
            begin
                r.truncated    = 1'b1;
                r.message_done = 1'b1;
                phase          = ndef_pkg::FIELD_HEADER;
                truncs++;
            end
            if (r.message_done)
            begin
                recs_done = '0;
                messages++;
            end
            labels_due.push_back(r);
        endfunction

        function void match_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void match_label(ndef_pkg::result_t got);
            ndef_pkg::result_t want;
            if (labels_due.size() == 0)
            begin
                $error("label came out with no byte waiting for it");
                errors++;
                return;
            end
            want = labels_due.pop_front();
            match_field("field_kind", 8'(want.field_kind), 8'(got.field_kind));
            match_field("record_index", 8'(want.record_index), 8'(got.record_index));
            match_field("record_tnf", 8'(want.record_tnf), 8'(got.record_tnf));
            match_field("first_record", 8'(want.first_record), 8'(got.first_record));
            match_field("last_record", 8'(want.last_record), 8'(got.last_record));
            match_field("chunked", 8'(want.chunked), 8'(got.chunked));
            match_field("record_done", 8'(want.record_done), 8'(got.record_done));
            match_field("message_done", 8'(want.message_done), 8'(got.message_done));
            match_field("dropped", 8'(want.dropped), 8'(got.dropped));
            match_field("truncated", 8'(want.truncated), 8'(got.truncated));
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    int           src_idle_pct;
    int           snk_idle_pct;
    field_labeler labeler;

    ndef_byte_if  msg();
    ndef_label_if label();

    ndef_record_stream_parser_core #(
        .MAX_RECORDS(REC_SLOTS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg),
        .label (label)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        label.ready <= rst_n && ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin : watch_channels
        ndef_pkg::result_t got;
        if (rst_n && msg.valid && msg.ready)
            labeler.take_byte(msg.data_byte, msg.last_byte);
        if (rst_n && label.valid && label.ready)
        begin
            got.field_kind   = label.field_kind;
            got.record_index = label.record_index;
            got.record_tnf   = label.record_tnf;
            got.first_record = label.first_record;
            got.last_record  = label.last_record;
            got.chunked      = label.chunked;
            got.record_done  = label.record_done;
            got.message_done = label.message_done;
            got.dropped      = label.dropped;
            got.truncated    = label.truncated;
            labeler.match_label(got);
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic is_last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            msg.valid <= 1'b0;
            @(posedge clk);
        end
        msg.valid     <= 1'b1;
        msg.data_byte <= value;
        msg.last_byte <= is_last;
        @(posedge clk);
        while (!msg.ready)
            @(posedge clk);
    endtask

    task automatic send_buffer(input logic [7:0] bytes_q[$]);
        foreach (bytes_q[i])
            send_byte(bytes_q[i], i == bytes_q.size() - 1);
    endtask

    task automatic wait_drained();
        msg.valid <= 1'b0;
        @(posedge clk);
        while (labeler.labels_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic void append_record(ref logic [7:0] bytes_q[$], input bit is_first,
                                          input bit is_end);
        logic [7:0]     raw;
        ndef_pkg::hdr_t h;
        int             tl;
        int             il_len;
        int             pl;
        raw    = 8'($urandom_range(255));
        h      = raw;
        h.mb   = is_first ? ($urandom_range(9) != 0) : ($urandom_range(9) == 0);
        h.me   = is_end;
        h.sr   = ($urandom_range(9) < 7);
        tl     = $urandom_range(3);
        il_len = h.il ? $urandom_range(3) : 0;
        pl     = ($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(6);
        if (h.sr && pl > 255)
            pl = 255;
        bytes_q.push_back(h);
        bytes_q.push_back(tl[7:0]);
        if (h.sr)
            bytes_q.push_back(pl[7:0]);
        else
        begin
            bytes_q.push_back(pl[31:24]);
            bytes_q.push_back(pl[23:16]);
            bytes_q.push_back(pl[15:8]);
            bytes_q.push_back(pl[7:0]);
        end
        if (h.il)
            bytes_q.push_back(il_len[7:0]);
        repeat (tl + il_len + pl)
            bytes_q.push_back(8'($urandom_range(255)));
    endfunction

    task automatic send_random_message();
        logic [7:0] bytes_q[$];
        logic [7:0] raw;
        int         mode;
        int         nrec;
        int         keep;
        mode = $urandom_range(9);
        nrec = $urandom_range(1, 6);
        if (mode == 8)
        begin
            // noise with stray end marks, closed by an end mark to resync
            repeat ($urandom_range(1, 12))
                send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
            send_byte(8'($urandom_range(255)), 1'b1);
        end
        else if (mode == 9)
        begin
            // long-form length with random bytes, nearly always cut short
            raw    = 8'($urandom_range(255));
            raw[4] = 1'b0;
            bytes_q.push_back(raw);
            repeat ($urandom_range(5, 13))
                bytes_q.push_back(8'($urandom_range(255)));
            send_buffer(bytes_q);
        end
        else
        begin
            for (int i = 0; i < nrec; i++)
                append_record(bytes_q, i == 0, mode < 4 && i == nrec - 1);
            if (mode < 4)
            begin
                repeat ($urandom_range(3))
                    bytes_q.push_back(8'($urandom_range(255)));
            end
            else if (mode >= 6 && bytes_q.size() > 1)
            begin
                keep = $urandom_range(1, bytes_q.size() - 1);
                while (bytes_q.size() > keep)
                    void'(bytes_q.pop_back());
            end
            send_buffer(bytes_q);
        end
    endtask

    task automatic run_directed();
        logic [7:0] seq_q[$];
        // empty short record with MB and ME, then two skipped bytes
        seq_q = '{8'hD0, 8'h00, 8'h00, 8'hFF, 8'h00};
        send_buffer(seq_q);
        // long-form length with IL and TNF 7, ends on the buffer end
        seq_q = '{8'h8F, 8'h01, 8'h00, 8'h00, 8'h00, 8'h02, 8'h01, 8'hAA, 8'h55,
                  8'h01, 8'h02};
        send_buffer(seq_q);
        // ME record completing on the buffer end
        seq_q = '{8'h51, 8'h00, 8'h01, 8'hFF};
        send_buffer(seq_q);
        // chunked record cut inside its length
        seq_q = '{8'h20, 8'hFF, 8'hFF};
        send_buffer(seq_q);
    endtask

    initial
    begin
        msg.valid       = 1'b0;
        msg.data_byte   = '0;
        msg.last_byte   = 1'b0;
        rst_n           = 1'b0;
        src_idle_pct    = 23;
        snk_idle_pct    = 59;
        labeler         = new(REC_SLOTS);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int p = 0; p < 3; p++)
        begin
            case (p)
                0:
                begin
                    src_idle_pct = 23;
                    snk_idle_pct = 59;
                end
                1:
                begin
                    src_idle_pct = 59;
                    snk_idle_pct = 23;
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            while (labeler.labelled < TARGET_BYTES * (p + 1) / 3)
                send_random_message();
            // hold the byte side until every label is out
            wait_drained();
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (labeler.labels_due.size() != 0)
        begin
            $error("%0d labels never came out", labeler.labels_due.size());
            labeler.errors++;
        end
        $display("labelled %0d bytes and skipped %0d over %0d messages, %0d records",
                 labeler.labelled, labeler.ignored, labeler.messages, labeler.records);
        $display("%0d records fell outside the table, %0d buffers ended mid-record",
                 labeler.drops, labeler.truncs);
        if (labeler.errors == 0)
            $display("tb_ndef_record_stream_parser_core OK");
        else
            $display("tb_ndef_record_stream_parser_core NOT OK");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("tb_ndef_record_stream_parser_core NOT OK");
        $finish;
    end

endmodule

>>> sim.f
design/ndef_pkg.sv
design/ndef_byte_if.sv
design/ndef_label_if.sv
design/ndef_front.sv
design/ndef_queue.sv
design/ndef_back.sv
design/ndef_record_stream_parser_core.sv
test/tb_ndef_record_stream_parser_core.sv
